[rtl/lssk_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the longest subarray sum block
package lssk_pkg;

   localparam int VAL_W       = 32;
   localparam int SUM_W       = 48;
   localparam int KEY_W       = SUM_W + 1;
   localparam int LEN_W       = 11;
   localparam int EPOCH_W     = 8;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [LEN_W-1:0] LEN_MAX = '1;

   typedef struct packed {
      logic signed [VAL_W-1:0] element_value;
      logic                    is_last;
   } req_type;

   typedef struct packed {
      logic [LEN_W-1:0] longest_length;
      logic             table_overflow;
   } rsp_type;

   typedef struct packed {
      logic active;
      logic last;
   } job_flags_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_LOOK_A,
      BK_PROBE_A,
      BK_LOOK_B,
      BK_PROBE_B,
      BK_FINISH
   } bk_state_type;

endpackage

[rtl/lssk_fifo.sv]
`timescale 1ns / 1ps
// short job queue between the front and back parts
module lssk_fifo
   import lssk_pkg::*;
#(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output fifo_status_type   status
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   logic [DATA_W-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign status.full  = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/lssk_front.sv]
`timescale 1ns / 1ps
// front part: takes requests, keeps the prefix sum and element count, queues jobs
module lssk_front
   import lssk_pkg::*;
#(
   parameter int MAX_ITEMS = 1024,
   parameter int IDX_W     = 11
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  req_type                 req_data,
   input  fifo_status_type         q_status,
   output logic                    push,
   output logic signed [SUM_W-1:0] job_sum,
   output logic [IDX_W-1:0]        job_idx,
   output job_flags_type           job_flags
);

   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [IDX_W-1:0]        count_ff, count_in;
   logic                    accept;
   logic                    active;
   logic signed [SUM_W-1:0] sum_next;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;
   // elements past the limit are dropped; the count stays pinned at the limit and the sum is held
   assign active    = (count_ff < IDX_W'(MAX_ITEMS));
   assign sum_next  = sum_ff + {{(SUM_W-VAL_W){req_data.element_value[VAL_W-1]}},
                                req_data.element_value};

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (accept) begin
         if (req_data.is_last) begin
            sum_in   = '0;
            count_in = '0;
         end else if (active) begin
            sum_in   = sum_next;
            count_in = count_ff + 1'b1;
         end
      end
   end

   assign push             = accept && (active || req_data.is_last);
   assign job_sum          = sum_next;
   assign job_idx          = count_ff;
   assign job_flags.active = active;
   assign job_flags.last   = req_data.is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

endmodule

[rtl/lssk_back.sv]
`timescale 1ns / 1ps
// back part: hashed prefix table lookups and inserts, best length, result register
module lssk_back
   import lssk_pkg::*;
#(
   parameter int IDX_W  = 11,
   parameter int TBL_AW = 11
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic signed [VAL_W-1:0] target_sum,
   input  fifo_status_type         q_status,
   output logic                    pop,
   input  logic signed [SUM_W-1:0] job_sum,
   input  logic [IDX_W-1:0]        job_idx,
   input  job_flags_type           job_flags,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsp_type                 rsp_data
);

   localparam int TBL_DEPTH = 1 << TBL_AW;
   localparam int EXT_W     = (IDX_W > LEN_W) ? IDX_W : LEN_W;

   typedef struct packed {
      logic [EPOCH_W-1:0] epoch;
      logic [KEY_W-1:0]   key;
      logic [IDX_W-1:0]   idx;
   } entry_type;

   entry_type tbl_mem [TBL_DEPTH];

   bk_state_type       state_ff, state_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic [TBL_AW-1:0]  clr_addr_ff, clr_addr_in;
   logic [TBL_AW-1:0]  probe_ff, probe_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [KEY_W-1:0]   sumk_ff, sumk_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   job_flags_type      flags_ff, flags_in;
   logic [IDX_W-1:0]   best_ff, best_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   entry_type          rd_data_ff;

   logic [TBL_AW-1:0]  rd_addr;
   logic               wr_en;
   logic [TBL_AW-1:0]  wr_addr;
   entry_type          wr_data;

   logic [KEY_W-1:0]   job_sumk;
   logic [KEY_W-1:0]   job_key;
   logic               ent_live;
   logic               a_hit, a_done;
   logic               b_hit, b_done;
   logic               out_free;
   logic [IDX_W-1:0]   cand_self;
   logic [IDX_W-1:0]   cand_hit;
   logic [EXT_W-1:0]   best_ext;
   logic [LEN_W-1:0]   len_sat;

   // fold every key bit onto the address bits
   function automatic logic [TBL_AW-1:0] hash_key(input logic [KEY_W-1:0] key);
      logic [TBL_AW-1:0] h;
      h = '0;
      for (int b = 0; b < KEY_W; b++) begin
         h[b % TBL_AW] ^= key[b];
      end
      return h;
   endfunction

   assign job_sumk = {job_sum[SUM_W-1], job_sum};
   assign job_key  = job_sumk - {{(KEY_W-VAL_W){target_sum[VAL_W-1]}}, target_sum};

   // entries from older arrays carry a stale epoch and count as empty
   assign ent_live  = (rd_data_ff.epoch == epoch_ff);
   assign a_hit     = ent_live && (rd_data_ff.key == key_ff);
   assign a_done    = !ent_live || a_hit;
   assign b_hit     = ent_live && (rd_data_ff.key == sumk_ff);
   assign b_done    = !ent_live || b_hit;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cand_self = idx_ff + IDX_W'(1);
   assign cand_hit  = idx_ff - rd_data_ff.idx;
   assign best_ext  = EXT_W'(best_ff);
   assign len_sat   = (best_ext > EXT_W'(LEN_MAX)) ? LEN_MAX : best_ext[LEN_W-1:0];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_CLEAR: begin
            if (clr_addr_ff == '1) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (!q_status.empty) begin
               state_in = job_flags.active ? BK_LOOK_A : BK_FINISH;
            end
         end
         BK_LOOK_A: begin
            state_in = BK_PROBE_A;
         end
         BK_PROBE_A: begin
            if (a_done) begin
               state_in = BK_LOOK_B;
            end
         end
         BK_LOOK_B: begin
            state_in = BK_PROBE_B;
         end
         BK_PROBE_B: begin
            if (b_done) begin
               state_in = flags_ff.last ? BK_FINISH : BK_IDLE;
            end
         end
         BK_FINISH: begin
            if (out_free) begin
               state_in = (epoch_ff == '1) ? BK_CLEAR : BK_IDLE;
            end
         end
         default: begin
            state_in = BK_CLEAR;
         end
      endcase
   end

   always_comb begin
      pop          = 1'b0;
      rd_addr      = probe_ff;
      wr_en        = 1'b0;
      wr_addr      = probe_ff;
      wr_data      = '0;
      probe_in     = probe_ff;
      clr_addr_in  = clr_addr_ff;
      epoch_in     = epoch_ff;
      key_in       = key_ff;
      sumk_in      = sumk_ff;
      idx_in       = idx_ff;
      flags_in     = flags_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         BK_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
         end
         BK_IDLE: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               sumk_in  = job_sumk;
               key_in   = job_key;
               idx_in   = job_idx;
               flags_in = job_flags;
            end
         end
         BK_LOOK_A: begin
            rd_addr  = hash_key(key_ff);
            probe_in = hash_key(key_ff);
            // running sum equals the target: whole prefix matches
            if ((key_ff == '0) && (cand_self > best_ff)) begin
               best_in = cand_self;
            end
         end
         BK_PROBE_A: begin
            if (a_hit) begin
               if (cand_hit > best_ff) begin
                  best_in = cand_hit;
               end
            end else if (ent_live) begin
               rd_addr  = probe_ff + 1'b1;
               probe_in = probe_ff + 1'b1;
            end
         end
         BK_LOOK_B: begin
            rd_addr  = hash_key(sumk_ff);
            probe_in = hash_key(sumk_ff);
         end
         BK_PROBE_B: begin
            if (!ent_live) begin
               wr_en         = 1'b1;
               wr_data.epoch = epoch_ff;
               wr_data.key   = sumk_ff;
               wr_data.idx   = idx_ff;
            end else if (!b_hit) begin
               rd_addr  = probe_ff + 1'b1;
               probe_in = probe_ff + 1'b1;
            end
         end
         BK_FINISH: begin
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.longest_length  = len_sat;
               rsp_data_in.table_overflow  = !flags_ff.active;
               best_in                     = '0;
               if (epoch_ff == '1) begin
                  epoch_in    = EPOCH_W'(1);
                  clr_addr_in = '0;
               end else begin
                  epoch_in = epoch_ff + 1'b1;
               end
            end
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         epoch_ff     <= EPOCH_W'(1);
         clr_addr_ff  <= '0;
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         epoch_ff     <= epoch_in;
         clr_addr_ff  <= clr_addr_in;
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      probe_ff    <= probe_in;
      key_ff      <= key_in;
      sumk_ff     <= sumk_in;
      idx_ff      <= idx_in;
      flags_ff    <= flags_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tbl_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= tbl_mem[rd_addr];
   end

endmodule

[rtl/longest_subarray_sum_k.sv]
`timescale 1ns / 1ps
// top level of the longest subarray with sum k block
//
//   port group   dir   handshake             payload
//   req_         in    req_valid/req_stall   req_type: element_value, is_last
//   rsp_         out   rsp_valid/rsp_stall   rsp_type: longest_length, table_overflow
//   csr_         in    csr_wr_en             csr_wr_data: target_sum
//
// the front takes one request per cycle while the four-entry job queue has room
// the back steps each element through IDLE, LOOK_A, PROBE_A, LOOK_B and PROBE_B,
//   repeating PROBE_A or PROBE_B per extra probe (linear probing, one-read-port table)
// an array's last element also passes FINISH, which loads the result register
// after reset and every 255 arrays, a clearing pass writes all 2^clog2(2*MAX_ITEMS)
//   table entries before the back takes the next job; requests queue meanwhile
// a waiting result stalls the back only when the next array's result is ready
module longest_subarray_sum_k
   import lssk_pkg::*;
#(
   parameter int MAX_ITEMS = 1024
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  req_type                 req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsp_type                 rsp_data,
   input  logic                    csr_wr_en,
   input  logic signed [VAL_W-1:0] csr_wr_data
);

   localparam int IDX_W   = $clog2(MAX_ITEMS + 1);
   localparam int TBL_AW  = $clog2(2 * MAX_ITEMS);
   localparam int FLAGS_W = $bits(job_flags_type);
   localparam int JOB_W   = SUM_W + IDX_W + FLAGS_W;

   logic signed [VAL_W-1:0] target_ff, target_in;

   fifo_status_type         q_status;
   logic                    q_push;
   logic                    q_pop;
   logic [JOB_W-1:0]        q_push_data;
   logic [JOB_W-1:0]        q_pop_data;

   logic signed [SUM_W-1:0] f_sum;
   logic [IDX_W-1:0]        f_idx;
   job_flags_type           f_flags;
   logic signed [SUM_W-1:0] b_sum;
   logic [IDX_W-1:0]        b_idx;
   job_flags_type           b_flags;

   assign target_in = csr_wr_en ? csr_wr_data : target_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else begin
         target_ff <= target_in;
      end
   end

   lssk_front #(
      .MAX_ITEMS (MAX_ITEMS),
      .IDX_W     (IDX_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_status  (q_status),
      .push      (q_push),
      .job_sum   (f_sum),
      .job_idx   (f_idx),
      .job_flags (f_flags)
   );

   assign q_push_data = {f_sum, f_idx, f_flags};

   lssk_fifo #(
      .DATA_W (JOB_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   assign b_sum   = q_pop_data[JOB_W-1 -: SUM_W];
   assign b_idx   = q_pop_data[FLAGS_W +: IDX_W];
   assign b_flags = q_pop_data[FLAGS_W-1:0];

   lssk_back #(
      .IDX_W  (IDX_W),
      .TBL_AW (TBL_AW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .target_sum (target_ff),
      .q_status   (q_status),
      .pop        (q_pop),
      .job_sum    (b_sum),
      .job_idx    (b_idx),
      .job_flags  (b_flags),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   a_queue_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_status.full))
      else $error("job queue written while full");

   a_queue_no_underrun: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_status.empty))
      else $error("job queue read while empty");

   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_data.longest_length) <= 32'(MAX_ITEMS)))
      else $error("reported length exceeds the element limit");

endmodule

[test/longest_subarray_sum_k_tb.sv]
`timescale 1ns / 1ps
// testbench for longest_subarray_sum_k: directed and random arrays checked against a prefix-sum predictor
module longest_subarray_sum_k_tb;
   import lssk_pkg::*;

   localparam int MAX_ELEMS    = 1024;
   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_ITEMS  = 30;

   typedef enum {SMALL_VALS, FULL_VALS, MIXED_VALS} value_mode_type;

   class length_scoreboard;
      longint      target_sum;
      longint      prefix_sum;
      int unsigned elem_count;
      int unsigned best_len;
      bit          overflowed;
      int unsigned first_index[longint];
      rsp_type     expected_lengths[$];
      int          errors;
      int          checked;

      function new();
         target_sum = 0;
         errors     = 0;
         checked    = 0;
         clear_array();
      endfunction

      function void clear_array();
         prefix_sum = 0;
         elem_count = 0;
         best_len   = 0;
         overflowed = 0;
         first_index.delete();
      endfunction

      function int pending();
         return expected_lengths.size();
      endfunction

      // predicts the effect of one accepted request
      function void note_element(req_type r);
         longint      key;
         int unsigned i;
         int unsigned len;
         rsp_type     e;
         if (elem_count >= MAX_ELEMS) begin
            overflowed = 1;
         end else begin
            i = elem_count;
            prefix_sum += longint'(r.element_value);
            if (prefix_sum == target_sum && i + 1 > best_len)
               best_len = i + 1;
            key = prefix_sum - target_sum;
            if (first_index.exists(key)) begin
               len = i - first_index[key];
               if (len > best_len)
                  best_len = len;
            end
            if (!first_index.exists(prefix_sum))
               first_index[prefix_sum] = i;
            elem_count = i + 1;
         end
         if (r.is_last) begin
            e.longest_length = (best_len > LEN_MAX) ? LEN_MAX : best_len[LEN_W-1:0];
            e.table_overflow = overflowed;
            expected_lengths = {expected_lengths, e};
            clear_array();
         end
      endfunction

      function void check_length(rsp_type got);
         rsp_type e;
         checked++;
         if (expected_lengths.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("[%0t] unexpected result: length %0d overflow %0b",
                        $realtime, got.longest_length, got.table_overflow);
         end else begin
            e = expected_lengths.pop_front();
            if (got.longest_length !== e.longest_length
                || got.table_overflow !== e.table_overflow) begin
               errors++;
               if (errors <= 10)
                  $display("[%0t] mismatch: length exp %0d got %0d, overflow exp %0b got %0b",
                           $realtime, e.longest_length, got.longest_length,
                           e.table_overflow, got.table_overflow);
            end
         end
      endfunction
   endclass

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_valid   = 1'b0;
   logic                    req_stall;
   req_type                 req_data    = '0;
   logic                    rsp_valid;
   logic                    rsp_stall   = 1'b0;
   rsp_type                 rsp_data;
   logic                    csr_wr_en   = 1'b0;
   logic signed [VAL_W-1:0] csr_wr_data = '0;

   length_scoreboard board = new();
   int burst_left = 0;
   int cycles     = 0;

   longest_subarray_sum_k #(
      .MAX_ITEMS(MAX_ELEMS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_length(rsp_data);
   end

   // receiver: changing stall patterns plus one long hold-off to back up the block
   initial begin : receiver
      int mode;
      int left;
      int hold_left;
      bit hold_done;
      mode      = 0;
      left      = 0;
      hold_left = 0;
      hold_done = 0;
      forever begin
         @(negedge clock);
         if (!hold_done && board.checked >= 3) begin
            hold_done = 1;
            hold_left = 500;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (left == 0) begin
               mode = $urandom_range(3);
               left = $urandom_range(200, 10);
            end
            left--;
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(3) == 0);
               2: rsp_stall <= ($urandom_range(9) < 7);
               default: rsp_stall <= ((left % 6) < 3);
            endcase
         end
      end
   end

   // offers one request, with bursts and random gaps, and waits for it to be taken
   task automatic send_element(req_type item);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(4) == 0) ? 0 : $urandom_range(12, 1);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = ($urandom_range(7) == 0) ? 200 : $urandom_range(40, 1);
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_element(item);
   endtask

   function automatic logic [VAL_W-1:0] pick_value(value_mode_type mode);
      int          r;
      logic [VAL_W-1:0] t;
      t = board.target_sum[VAL_W-1:0];
      case (mode)
         SMALL_VALS: return $urandom_range(8) - 4;
         FULL_VALS:  return $urandom();
         default: begin
            r = $urandom_range(9);
            case (r)
               0, 1, 2, 3: return $urandom_range(8) - 4;
               4, 5:       return $urandom();
               6:          return 32'h7FFF_FFFF;
               7:          return 32'h8000_0000;
               8:          return t + $urandom_range(4) - 2;
               default:    return -t;
            endcase
         end
      endcase
   endfunction

   task automatic send_array(int len, value_mode_type mode);
      req_type item;
      for (int k = 0; k < len; k++) begin
         item.element_value = pick_value(mode);
         item.is_last       = (k == len - 1);
         send_element(item);
      end
   endtask

   // block must be idle: no result pending and the back end given time to finish
   task automatic write_target(logic signed [VAL_W-1:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      board.target_sum = longint'(value);
   endtask

   initial begin : stimulus
      logic [VAL_W-1:0] dir_vals [15];
      bit               dir_last [15];
      req_type          item;
      int               phase_items;
      int               len;
      int               r;
      value_mode_type   mode;
      logic signed [VAL_W-1:0] targets [8];

      dir_vals = '{32'd0, 32'd7, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'h8000_0000,
                   32'd3, -32'sd3, 32'd3, -32'sd3, 32'd1, 32'd2, -32'sd3, 32'd5,
                   32'hFFFF_FFFF};
      dir_last = '{1, 1, 0, 0, 1, 1, 0, 0, 0, 1, 0, 0, 0, 1, 1};
      targets  = '{32'sd0, 32'sd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd3, -32'sd5,
                   32'sd0, 32'sd1};
      targets[6] = $urandom();

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: zero element, no match, extremes, cancelling pairs, inner match
      write_target(targets[0]);
      for (int k = 0; k < 15; k++) begin
         item.element_value = dir_vals[k];
         item.is_last       = dir_last[k];
         send_element(item);
      end

      for (int p = 1; p < 8; p++) begin
         write_target(targets[p]);
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            if (p == 7) begin
               // many tiny arrays in a row
               len = $urandom_range(2, 1);
            end else begin
               r = $urandom_range(99);
               if (r < 55)      len = $urandom_range(3, 1);
               else if (r < 85) len = $urandom_range(12, 4);
               else if (r < 97) len = $urandom_range(40, 13);
               else             len = $urandom_range(100, 41);
            end
            r = $urandom_range(99);
            mode = (r < 50) ? SMALL_VALS : (r < 85) ? MIXED_VALS : FULL_VALS;
            send_array(len, mode);
            phase_items += len;
         end
         // one array that runs past the element limit
         if (p == 3)
            send_array(MAX_ELEMS + 5, MIXED_VALS);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
